/* hw/rtl/range_list_parser_defines.svh */
// Assertion helpers used by the parser back end (rlp_back).
`ifndef RANGE_LIST_PARSER_DEFINES_SVH
`define RANGE_LIST_PARSER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RLP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("range_list_parser: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RLP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("range_list_parser: next-cycle check failed");

`endif

/* hw/rtl/rlp_pkg.sv */
`default_nettype none
package rlp_pkg;

    localparam int NUM_W   = 32;
    localparam int CHAR_W  = 8;
    localparam int CFG_IDX_W = 2;

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // character kinds
    localparam logic [2:0] CK_DIGIT = 3'd0;
    localparam logic [2:0] CK_COMMA = 3'd1;
    localparam logic [2:0] CK_DASH  = 3'd2;
    localparam logic [2:0] CK_END   = 3'd3;
    localparam logic [2:0] CK_OTHER = 3'd4;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOWEST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGHEST = 2'd1;

    // result status
    localparam logic [1:0] ST_CONT    = 2'd0;
    localparam logic [1:0] ST_ACCEPT  = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] digit;
    } char_class_t;

endpackage
`default_nettype wire

/* hw/rtl/range_list_parser.sv */
// An accepted character is written into the queue, then popped into the back end's registered result (m_valid).
// Throughput: one character per cycle while m_ready keeps the output drained, set by the combinational shift-add
// accumulate and bound compares in the back end.
// A 2-entry queue between classifier and parser lets each side stall alone.
// Reset (aresetn low, synchronous): parser at string start, queue and output
// empty, range_lowest = 0, range_highest = all ones.
`default_nettype none
module range_list_parser import rlp_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [NUM_W-1:0]     cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [CHAR_W-1:0]    s_char_code,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_range_valid,
    output logic [NUM_W-1:0]          m_range_low,
    output logic [NUM_W-1:0]          m_range_high,
    output logic [1:0]                m_status
);

    logic        q_full;
    logic        q_push;
    char_class_t q_entry;
    logic        q_pop;
    logic        q_head_valid;
    char_class_t q_head;

    rlp_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    rlp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head)
    );

    rlp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .head_valid    (q_head_valid),
        .head_entry    (q_head),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_range_valid (m_range_valid),
        .m_range_low   (m_range_low),
        .m_range_high  (m_range_high),
        .m_status      (m_status)
    );

endmodule
`default_nettype wire

/* hw/rtl/rlp_front.sv */
`default_nettype none
module rlp_front import rlp_pkg::*; (
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CHAR_W-1:0] s_char_code,
    input  wire logic              q_full,
    output logic                   q_push,
    output char_class_t            q_entry
);

    logic [3:0] digit_off;

    assign s_ready   = !q_full;
    assign q_push    = s_valid && !q_full;
    // '0' has a zero low nibble, so the digit value is the low nibble
    assign digit_off = s_char_code[3:0] - CHAR_ZERO[3:0];

    always_comb begin
        q_entry.digit = digit_off;
        if (s_char_code inside {[CHAR_ZERO:CHAR_NINE]}) begin
            q_entry.kind = CK_DIGIT;
        end else if (s_char_code == CHAR_COMMA) begin
            q_entry.kind = CK_COMMA;
        end else if (s_char_code == CHAR_DASH) begin
            q_entry.kind = CK_DASH;
        end else if (s_char_code == CHAR_NUL) begin
            q_entry.kind = CK_END;
        end else begin
            q_entry.kind = CK_OTHER;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/rlp_queue.sv */
`default_nettype none
module rlp_queue import rlp_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire char_class_t push_entry,
    output logic             full,
    input  wire logic        pop,
    output logic             head_valid,
    output char_class_t      head_entry
);

    char_class_t         mem_reg [Q_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/rlp_back.sv */
`default_nettype none
`include "range_list_parser_defines.svh"
module rlp_back import rlp_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [NUM_W-1:0]     cfg_data,
    input  wire logic                 head_valid,
    input  wire char_class_t          head_entry,
    output logic                      pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_range_valid,
    output logic [NUM_W-1:0]          m_range_low,
    output logic [NUM_W-1:0]          m_range_high,
    output logic [1:0]                m_status
);

    localparam logic [2:0] PH_START      = 3'd0;
    localparam logic [2:0] PH_ITEM       = 3'd1;
    localparam logic [2:0] PH_NUM1       = 3'd2;
    localparam logic [2:0] PH_DASH_LEAD  = 3'd3;
    localparam logic [2:0] PH_NUM_LEAD   = 3'd4;
    localparam logic [2:0] PH_DASH_AFTER = 3'd5;
    localparam logic [2:0] PH_NUM2       = 3'd6;

    logic [NUM_W-1:0] lowest_reg, highest_reg;
    logic [2:0]       phase_reg, phase_next;
    logic [NUM_W-1:0] first_reg, first_next;
    logic [NUM_W-1:0] cur_reg, cur_next;
    logic             ovf_reg, ovf_next;
    logic             err_reg, err_next;

    logic             m_valid_reg, m_valid_next;
    logic             rv_reg, rv_next;
    logic [NUM_W-1:0] lo_reg, lo_next;
    logic [NUM_W-1:0] hi_reg, hi_next;
    logic [1:0]       st_reg, st_next;

    logic [NUM_W+3:0] acc;
    logic             acc_ovf;
    logic             num_ok;
    logic             is_end;
    logic             is_digit;
    logic [2:0]       kind;

    assign pop           = head_valid && (!m_valid_reg || m_ready);
    assign m_valid       = m_valid_reg;
    assign m_range_valid = rv_reg;
    assign m_range_low   = lo_reg;
    assign m_range_high  = hi_reg;
    assign m_status      = st_reg;

    assign kind     = head_entry.kind;
    assign is_end   = (kind == CK_END);
    assign is_digit = (kind == CK_DIGIT);

    // cur*10 + d as shift-add; anything above NUM_W bits is overflow
    assign acc     = ({4'b0, cur_reg} << 3) + ({4'b0, cur_reg} << 1)
                   + {{NUM_W{1'b0}}, head_entry.digit};
    assign acc_ovf = |acc[NUM_W+3:NUM_W];
    assign num_ok  = !ovf_reg && (cur_reg >= lowest_reg) && (cur_reg <= highest_reg);

    always_comb begin
        logic do_clear;
        logic do_reject;
        logic do_close;
        logic do_add;
        logic do_start;

        do_clear  = 1'b0;
        do_reject = 1'b0;
        do_close  = 1'b0;
        do_add    = 1'b0;
        do_start  = 1'b0;

        phase_next = phase_reg;
        first_next = first_reg;
        cur_next   = cur_reg;
        ovf_next   = ovf_reg;
        err_next   = err_reg;
        rv_next    = 1'b0;
        lo_next    = '0;
        hi_next    = '0;
        st_next    = ST_CONT;

        if (err_reg) begin
            do_clear = is_end;
            st_next  = ST_IGNORED;
        end else begin
            case (phase_reg)
                PH_START, PH_ITEM: begin
                    if (is_end && phase_reg == PH_START) begin
                        do_clear = 1'b1;
                        st_next  = ST_ACCEPT;
                    end else if (kind == CK_DASH) begin
                        phase_next = PH_DASH_LEAD;
                    end else if (is_digit) begin
                        do_start   = 1'b1;
                        phase_next = PH_NUM1;
                    end else begin
                        do_reject = 1'b1;
                    end
                end
                PH_NUM1: begin
                    if (is_digit) begin
                        do_add = 1'b1;
                    end else if (!num_ok) begin
                        do_reject = 1'b1;
                    end else if (is_end) begin
                        rv_next  = 1'b1;
                        lo_next  = cur_reg;
                        hi_next  = cur_reg;
                        do_clear = 1'b1;
                        st_next  = ST_ACCEPT;
                    end else if (kind == CK_COMMA) begin
                        rv_next    = 1'b1;
                        lo_next    = cur_reg;
                        hi_next    = cur_reg;
                        phase_next = PH_ITEM;
                    end else if (kind == CK_DASH) begin
                        first_next = cur_reg;
                        phase_next = PH_DASH_AFTER;
                    end else begin
                        do_reject = 1'b1;
                    end
                end
                PH_DASH_LEAD: begin
                    if (is_digit) begin
                        do_start   = 1'b1;
                        phase_next = PH_NUM_LEAD;
                    end else begin
                        do_reject = 1'b1;
                    end
                end
                PH_DASH_AFTER: begin
                    if (is_digit) begin
                        do_start   = 1'b1;
                        phase_next = PH_NUM2;
                    end else if (is_end || kind == CK_COMMA) begin
                        rv_next  = 1'b1;
                        lo_next  = first_reg;
                        hi_next  = highest_reg;
                        do_close = 1'b1;
                    end else begin
                        do_reject = 1'b1;
                    end
                end
                PH_NUM_LEAD, PH_NUM2: begin
                    if (is_digit) begin
                        do_add = 1'b1;
                    end else if (!num_ok) begin
                        do_reject = 1'b1;
                    end else begin
                        rv_next  = 1'b1;
                        lo_next  = (phase_reg == PH_NUM_LEAD) ? lowest_reg : first_reg;
                        hi_next  = cur_reg;
                        do_close = 1'b1;
                    end
                end
                default: begin
                    do_reject = 1'b1;
                end
            endcase

            // closing number: range is out; comma continues, end accepts, anything else rejects
            if (do_close) begin
                if (is_end) begin
                    do_clear = 1'b1;
                    st_next  = ST_ACCEPT;
                end else if (kind == CK_COMMA) begin
                    phase_next = PH_ITEM;
                end else begin
                    do_reject = 1'b1;
                end
            end

            if (do_reject) begin
                st_next = ST_REJECT;
                if (is_end) begin
                    do_clear = 1'b1;
                end else begin
                    err_next = 1'b1;
                end
            end
        end

        if (do_start) begin
            cur_next = {{(NUM_W-4){1'b0}}, head_entry.digit};
            ovf_next = 1'b0;
        end

        if (do_add && !ovf_reg) begin
            if (acc_ovf) begin
                ovf_next = 1'b1;
            end else begin
                cur_next = acc[NUM_W-1:0];
            end
        end

        if (do_clear) begin
            phase_next = PH_START;
            first_next = '0;
            cur_next   = '0;
            ovf_next   = 1'b0;
            err_next   = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lowest_reg  <= '0;
            highest_reg <= '1;
            phase_reg   <= PH_START;
            first_reg   <= '0;
            cur_reg     <= '0;
            ovf_reg     <= 1'b0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_index == REG_LOWEST) begin
                lowest_reg <= cfg_data;
            end
            if (cfg_wr_en && cfg_index == REG_HIGHEST) begin
                highest_reg <= cfg_data;
            end
            if (pop) begin
                phase_reg <= phase_next;
                first_reg <= first_next;
                cur_reg   <= cur_next;
                ovf_reg   <= ovf_next;
                err_reg   <= err_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            rv_reg <= rv_next;
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            st_reg <= st_next;
        end
    end

    // an ignored character never carries a range
    `RLP_ASSERT_NOW(a_ignored_no_range, m_valid_reg && rv_reg, st_reg != ST_IGNORED)
    // overflow only lives inside a number unless an error is latched
    `RLP_ASSERT_NOW(a_ovf_in_number, ovf_reg && !err_reg,
        phase_reg == PH_NUM1 || phase_reg == PH_NUM_LEAD || phase_reg == PH_NUM2)
    // an accepted string returns the parser to string start
    `RLP_ASSERT_NEXT(a_accept_resets, pop && st_next == ST_ACCEPT,
        phase_reg == PH_START && !err_reg && !ovf_reg)
    // a request is only taken from a non-empty queue
    `RLP_ASSERT_NOW(a_pop_has_data, pop, head_valid)

endmodule
`default_nettype wire

/* sim/tb_range_list_parser.sv */
`timescale 1ns / 100ps

module tb_range_list_parser import rlp_pkg::*;;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic [NUM_W-1:0]     NUM_ALL_ONES = {NUM_W{1'b1}};
    localparam int                   ITEMS_PER_PHASE = 120;
    localparam int                   NUM_PHASES = 9;

    typedef enum logic [2:0] {
        PS_START,
        PS_ITEM,
        PS_NUM1,
        PS_DASH_LEAD,
        PS_NUM_LEAD,
        PS_DASH_AFTER,
        PS_NUM2
    } parse_phase_e;

    typedef struct packed {
        logic             range_valid;
        logic [NUM_W-1:0] range_low;
        logic [NUM_W-1:0] range_high;
        logic [1:0]       status;
    } char_outcome_t;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              typed;
        char_outcome_t     want;
    } step_row_t;

    localparam int N_DIRECTED = 26;
    localparam step_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{CHAR_NUL,   1'b1, '{1'b0, 32'd0, 32'd0, ST_ACCEPT}},   // empty string
        '{CHAR_DASH,  1'b1, '{1'b0, 32'd0, 32'd0, ST_CONT}},     // "-5," lowest..5
        '{"5",        1'b0, '0},
        '{CHAR_COMMA, 1'b0, '0},
        '{"9",        1'b0, '0},                                 // "9-3," reversed
        '{CHAR_DASH,  1'b0, '0},
        '{"3",        1'b0, '0},
        '{CHAR_COMMA, 1'b0, '0},
        '{"7",        1'b0, '0},                                 // "7-" to highest
        '{CHAR_DASH,  1'b0, '0},
        '{CHAR_NUL,   1'b1, '{1'b1, 32'd7, 32'hFFFF_FFFF, ST_ACCEPT}},
        '{CHAR_COMMA, 1'b1, '{1'b0, 32'd0, 32'd0, ST_REJECT}},   // leading comma
        '{"1",        1'b1, '{1'b0, 32'd0, 32'd0, ST_IGNORED}},
        '{CHAR_NUL,   1'b1, '{1'b0, 32'd0, 32'd0, ST_IGNORED}},
        '{"1",        1'b0, '0},                                 // stray char after number
        '{"x",        1'b1, '{1'b0, 32'd0, 32'd0, ST_REJECT}},
        '{CHAR_NUL,   1'b1, '{1'b0, 32'd0, 32'd0, ST_IGNORED}},
        '{CHAR_DASH,  1'b0, '0},                                 // junk after closing number
        '{"2",        1'b0, '0},
        '{"a",        1'b1, '{1'b1, 32'd0, 32'd2, ST_REJECT}},
        '{CHAR_NUL,   1'b1, '{1'b0, 32'd0, 32'd0, ST_IGNORED}},
        '{"3",        1'b0, '0},                                 // trailing comma
        '{CHAR_COMMA, 1'b0, '0},
        '{CHAR_NUL,   1'b1, '{1'b0, 32'd0, 32'd0, ST_REJECT}},
        '{CHAR_DASH,  1'b0, '0},                                 // dash alone
        '{CHAR_NUL,   1'b1, '{1'b0, 32'd0, 32'd0, ST_REJECT}}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [NUM_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [CHAR_W-1:0]    s_char_code;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_range_valid;
    logic [NUM_W-1:0]     m_range_low;
    logic [NUM_W-1:0]     m_range_high;
    logic [1:0]           m_status;

    // parser mirror
    parse_phase_e     ps;
    logic [NUM_W-1:0] first_val;
    logic [NUM_W-1:0] acc_val;
    logic             acc_ovf;
    logic             in_error;
    logic [NUM_W-1:0] bound_lo;
    logic [NUM_W-1:0] bound_hi;

    char_outcome_t     outcome_q [$];
    logic [CHAR_W-1:0] text_q [$];
    int                mismatch_count = 0;
    int                parsed_count;
    int                src_idle_pct = 0;
    int                sink_idle_pct = 0;

    range_list_parser dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_range_valid (m_range_valid),
        .m_range_low   (m_range_low),
        .m_range_high  (m_range_high),
        .m_status      (m_status)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void restart_parse();
        ps = PS_START;
        first_val = '0;
        acc_val = '0;
        acc_ovf = 1'b0;
        in_error = 1'b0;
    endfunction

    // a terminator resets right away, anything else latches the error
    function automatic logic [1:0] reject_char(input logic [CHAR_W-1:0] c);
        if (c == CHAR_NUL) begin
            restart_parse();
        end else begin
            in_error = 1'b1;
        end
        return ST_REJECT;
    endfunction

    function automatic logic [1:0] close_range(input logic [CHAR_W-1:0] c);
        if (c == CHAR_NUL) begin
            restart_parse();
            return ST_ACCEPT;
        end
        if (c == CHAR_COMMA) begin
            ps = PS_ITEM;
            return ST_CONT;
        end
        return reject_char(c);
    endfunction

    // number freezes once it no longer fits
    function automatic void add_digit(input logic [NUM_W-1:0] d);
        if (acc_ovf) begin
            return;
        end
        if (acc_val > (NUM_ALL_ONES - d) / 10) begin
            acc_ovf = 1'b1;
        end else begin
            acc_val = acc_val * 10 + d;
        end
    endfunction

    function automatic char_outcome_t parse_char(input logic [CHAR_W-1:0] c);
        char_outcome_t r;
        logic          digit;
        logic [NUM_W-1:0] d;
        logic          num_ok;
        r = '0;
        r.status = ST_CONT;
        digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        d = NUM_W'(c) - NUM_W'(CHAR_ZERO);
        num_ok = !acc_ovf && acc_val >= bound_lo && acc_val <= bound_hi;
        if (in_error) begin
            if (c == CHAR_NUL) begin
                restart_parse();
            end
            r.status = ST_IGNORED;
            return r;
        end
        case (ps)
            PS_START, PS_ITEM: begin
                if (c == CHAR_NUL && ps == PS_START) begin
                    restart_parse();
                    r.status = ST_ACCEPT;
                end else if (c == CHAR_DASH) begin
                    ps = PS_DASH_LEAD;
                end else if (digit) begin
                    acc_val = d;
                    acc_ovf = 1'b0;
                    ps = PS_NUM1;
                end else begin
                    r.status = reject_char(c);
                end
            end
            PS_NUM1: begin
                if (digit) begin
                    add_digit(d);
                end else if (!num_ok) begin
                    r.status = reject_char(c);
                end else if (c == CHAR_NUL) begin
                    r = '{1'b1, acc_val, acc_val, ST_ACCEPT};
                    restart_parse();
                end else if (c == CHAR_COMMA) begin
                    r = '{1'b1, acc_val, acc_val, ST_CONT};
                    ps = PS_ITEM;
                end else if (c == CHAR_DASH) begin
                    first_val = acc_val;
                    ps = PS_DASH_AFTER;
                end else begin
                    r.status = reject_char(c);
                end
            end
            PS_DASH_LEAD: begin
                if (digit) begin
                    acc_val = d;
                    acc_ovf = 1'b0;
                    ps = PS_NUM_LEAD;
                end else begin
                    r.status = reject_char(c);
                end
            end
            PS_DASH_AFTER: begin
                if (digit) begin
                    acc_val = d;
                    acc_ovf = 1'b0;
                    ps = PS_NUM2;
                end else if (c == CHAR_NUL || c == CHAR_COMMA) begin
                    r.range_valid = 1'b1;
                    r.range_low = first_val;
                    r.range_high = bound_hi;
                    r.status = close_range(c);
                end else begin
                    r.status = reject_char(c);
                end
            end
            PS_NUM_LEAD, PS_NUM2: begin
                if (digit) begin
                    add_digit(d);
                end else if (!num_ok) begin
                    r.status = reject_char(c);
                end else begin
                    r.range_valid = 1'b1;
                    r.range_low = (ps == PS_NUM_LEAD) ? bound_lo : first_val;
                    r.range_high = acc_val;
                    r.status = close_range(c);
                end
            end
            default: begin
                r.status = reject_char(c);
            end
        endcase
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NUM_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        if (idx == REG_LOWEST) begin
            bound_lo = val;
        end else if (idx == REG_HIGHEST) begin
            bound_hi = val;
        end
    endtask

    // called at a falling edge, returns at a falling edge with s_valid still up
    task automatic feed_char(input logic [CHAR_W-1:0] code, input logic typed,
                             input char_outcome_t want);
        char_outcome_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_char_code <= code;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = parse_char(code);
        outcome_q.push_back(typed ? want : predicted);
        parsed_count++;
        @(negedge aclk);
    endtask

    task automatic push_number();
        string            txt;
        logic [NUM_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = bound_lo;
            1: v = bound_hi;
            2: v = bound_lo - 1;
            3: v = bound_hi + 1;
            4: v = '0;
            5: v = NUM_ALL_ONES;
            6: v = $urandom;
            default: v = $urandom_range(0, 999);
        endcase
        if ($urandom_range(0, 9) == 0) begin
            // too wide for the accumulator
            if ($urandom_range(0, 1) == 0) begin
                txt = "4294967296";
            end else begin
                txt = $sformatf("%0d%010d", $urandom_range(1, 9),
                                $urandom_range(0, 999999999));
            end
        end else begin
            txt = $sformatf("%0d", v);
        end
        if ($urandom_range(0, 7) == 0) begin
            text_q.push_back(CHAR_ZERO);
        end
        for (int i = 0; i < txt.len(); i++) begin
            text_q.push_back(txt[i]);
        end
    endtask

    task automatic build_string();
        int n_items;
        int pos;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) text_q.push_back(CHAR_W'($urandom_range(1, 255)));
            text_q.push_back(CHAR_NUL);
            return;
        end
        n_items = $urandom_range(0, 4);
        for (int i = 0; i < n_items; i++) begin
            if (i > 0) begin
                text_q.push_back(CHAR_COMMA);
            end
            case ($urandom_range(0, 3))
                0: push_number();
                1: begin
                    push_number();
                    text_q.push_back(CHAR_DASH);
                    push_number();
                end
                2: begin
                    push_number();
                    text_q.push_back(CHAR_DASH);
                end
                default: begin
                    text_q.push_back(CHAR_DASH);
                    push_number();
                end
            endcase
        end
        // break about one string in five
        if ($urandom_range(0, 4) == 0) begin
            pos = $urandom_range(0, text_q.size());
            case ($urandom_range(0, 2))
                0: text_q.insert(pos, CHAR_COMMA);
                1: text_q.insert(pos, CHAR_DASH);
                default: text_q.insert(pos, CHAR_W'($urandom_range(1, 255)));
            endcase
        end
        text_q.push_back(CHAR_NUL);
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        char_outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (outcome_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: rv=%0b lo=%0d hi=%0d st=%0d",
                             m_range_valid, m_range_low, m_range_high, m_status);
                end
            end else begin
                want = outcome_q.pop_front();
                if (m_range_valid !== want.range_valid || m_range_low !== want.range_low ||
                    m_range_high !== want.range_high || m_status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display({"mismatch: expected rv=%0b lo=%0d hi=%0d st=%0d,",
                                  " got rv=%0b lo=%0d hi=%0d st=%0d"},
                                 want.range_valid, want.range_low, want.range_high,
                                 want.status, m_range_valid, m_range_low, m_range_high,
                                 m_status);
                    end
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [NUM_W-1:0] lo_set;
        logic [NUM_W-1:0] hi_set;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_char_code = '0;
        m_ready = 1'b0;
        restart_parse();
        bound_lo = '0;
        bound_hi = NUM_ALL_ONES;
        parsed_count = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        src_idle_pct = 19;
        sink_idle_pct = 75;
        for (int i = 0; i < N_DIRECTED; i++) begin
            feed_char(DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            s_valid <= 1'b0;
            while (outcome_q.size() != 0) @(negedge aclk);
            repeat (4) @(negedge aclk);
            case (p / 3)
                0: begin
                    src_idle_pct = 19;
                    sink_idle_pct = 75;
                end
                1: begin
                    src_idle_pct = 75;
                    sink_idle_pct = 19;
                end
                default: begin
                    src_idle_pct = 0;
                    sink_idle_pct = 0;
                end
            endcase
            case (p)
                0: begin lo_set = '0;           hi_set = NUM_ALL_ONES; end
                1: begin lo_set = 10;           hi_set = 999; end
                2: begin lo_set = '0;           hi_set = '0; end
                3: begin lo_set = NUM_ALL_ONES; hi_set = NUM_ALL_ONES; end
                4: begin
                    lo_set = $urandom_range(0, 5000);
                    hi_set = lo_set + $urandom_range(0, 5000);
                end
                5: begin lo_set = 1000;         hi_set = 10; end  // empty window
                6: begin lo_set = '0;           hi_set = 65535; end
                7: begin lo_set = $urandom;     hi_set = $urandom; end
                default: begin lo_set = '0;     hi_set = NUM_ALL_ONES; end
            endcase
            write_reg(REG_LOWEST, lo_set);
            write_reg(REG_HIGHEST, hi_set);
            write_reg((p % 2 == 0) ? REG_SPARE_A : REG_SPARE_B, $urandom);
            parsed_count = 0;
            while (parsed_count < ITEMS_PER_PHASE) begin
                build_string();
                while (text_q.size() != 0) begin
                    feed_char(text_q.pop_front(), 1'b0, '0);
                end
            end
        end

        s_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && outcome_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
